>>> design/lexsym_pkg.sv
// shared types, token codes and operator tables of the lexer
`timescale 1ns / 1ps
package lexsym_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_DEC, M_ZERO, M_OCT, M_HEX, M_STR, M_CHR,
        M_SLASH, M_CMT, M_OP
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_LK_HREQ, S_LK_HCMP, S_LK_BREQ, S_LK_BCMP, S_EMIT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic commit_eval;
        logic lk_long;
        logic lk_start;
        logic lk_rd_hash;
        logic lk_next_i;
        logic lk_clr_j;
        logic lk_rd_name;
        logic lk_next_j;
        logic lk_hit;
        logic lk_miss;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic ident_flush;
        logic too_long;
        logic eval_emits;
        logic i_at_count;
        logic hash_match;
        logic j_at_len;
        logic byte_match;
        logic holds_empty;
    } status_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] value;
        logic [31:0] hash;
        logic [23:0] length;
        logic [23:0] start;
        logic [23:0] line;
        logic [7:0]  index;
        logic        is_new;
    } tok_t;

    localparam logic [5:0] K_END     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_NUMBER  = 6'd2;
    localparam logic [5:0] K_STRING  = 6'd3;
    localparam logic [5:0] K_DIVIDE  = 6'd4;
    localparam logic [5:0] K_ASSIGN  = 6'd5;
    localparam logic [5:0] K_EQ      = 6'd6;
    localparam logic [5:0] K_PLUS    = 6'd7;
    localparam logic [5:0] K_INC     = 6'd8;
    localparam logic [5:0] K_MINUS   = 6'd9;
    localparam logic [5:0] K_DEC     = 6'd10;
    localparam logic [5:0] K_NOT     = 6'd11;
    localparam logic [5:0] K_NE      = 6'd12;
    localparam logic [5:0] K_LT      = 6'd13;
    localparam logic [5:0] K_LE      = 6'd14;
    localparam logic [5:0] K_SHL     = 6'd15;
    localparam logic [5:0] K_GT      = 6'd16;
    localparam logic [5:0] K_GE      = 6'd17;
    localparam logic [5:0] K_SHR     = 6'd18;
    localparam logic [5:0] K_AND     = 6'd19;
    localparam logic [5:0] K_LAND    = 6'd20;
    localparam logic [5:0] K_OR      = 6'd21;
    localparam logic [5:0] K_LOR     = 6'd22;
    localparam logic [5:0] K_XOR     = 6'd23;
    localparam logic [5:0] K_STAR    = 6'd24;
    localparam logic [5:0] K_PERCENT = 6'd25;
    localparam logic [5:0] K_QUEST   = 6'd26;
    localparam logic [5:0] K_LBRACK  = 6'd27;
    localparam logic [5:0] K_RBRACK  = 6'd28;
    localparam logic [5:0] K_LBRACE  = 6'd29;
    localparam logic [5:0] K_RBRACE  = 6'd30;
    localparam logic [5:0] K_LPAREN  = 6'd31;
    localparam logic [5:0] K_RPAREN  = 6'd32;
    localparam logic [5:0] K_SEMI    = 6'd33;
    localparam logic [5:0] K_COMMA   = 6'd34;
    localparam logic [5:0] K_COLON   = 6'd35;
    localparam logic [5:0] K_BAD     = 6'd36;
    localparam logic [5:0] K_FULL    = 6'd37;
    localparam logic [5:0] K_LONG    = 6'd38;

    localparam logic [23:0] SAT24 = 24'hFFFFFF;

    function automatic logic [5:0] single_op(input logic [7:0] c);
        case (c)
            "=":     return K_ASSIGN;
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "!":     return K_NOT;
            "<":     return K_LT;
            ">":     return K_GT;
            "&":     return K_AND;
            "|":     return K_OR;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [5:0] double_op(input logic [7:0] f, input logic [7:0] c);
        case (f)
            "=":     return (c == "=") ? K_EQ : K_END;
            "+":     return (c == "+") ? K_INC : K_END;
            "-":     return (c == "-") ? K_DEC : K_END;
            "!":     return (c == "=") ? K_NE : K_END;
            "<":     return (c == "=") ? K_LE : ((c == "<") ? K_SHL : K_END);
            ">":     return (c == "=") ? K_GE : ((c == ">") ? K_SHR : K_END);
            "&":     return (c == "&") ? K_LAND : K_END;
            "|":     return (c == "|") ? K_LOR : K_END;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        case (c)
            "^":     return K_XOR;
            "*":     return K_STAR;
            "%":     return K_PERCENT;
            "?":     return K_QUEST;
            "[":     return K_LBRACK;
            "]":     return K_RBRACK;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            ";":     return K_SEMI;
            ",":     return K_COMMA;
            ":":     return K_COLON;
            default: return K_BAD;
        endcase
    endfunction

endpackage

>>> design/c_like_lexer_with_symbol_intern_top.sv
// top level of the streaming lexer with identifier interning
//
// input channel: one source byte per word (data_byte), or an end marker
// (end_of_input) that flushes the pending token and gives an end token.
// output channel: one token per word with its kind, value, hash, length,
// start offset, line, symbol index and a flag on the last token of a byte.
// an ordinary byte passes through intake and a scan step, then each token
// it releases is emitted in turn, and a drain step follows. an identifier
// end walks the symbol store: a start step, a read and compare of the hash
// of each held symbol in turn, a read and compare per name byte for each
// hash and length match, and a closing step, before the scan step resumes.
// an over-long name skips the walk.
// results wait in an output register; while the receiver stalls the block
// keeps that word steady and holds off new bytes until its tokens are out.
// reset empties the symbol store (by its count), sets the line to one and
// the byte offset to zero; no clearing pass is needed.
`timescale 1ns / 1ps
module c_like_lexer_with_symbol_intern_top #(
    parameter int SYM_DEPTH = 256,
    parameter int NAME_MAX  = 32,
    parameter int POS_BITS  = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_input,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         token_kind,
    output logic signed [31:0] number_value,
    output logic [31:0]        ident_hash,
    output logic [23:0]        token_length,
    output logic [23:0]        start_offset,
    output logic [23:0]        line_number,
    output logic [7:0]         symbol_index,
    output logic               new_symbol,
    output logic               last_of_run
);
    import lexsym_pkg::*;

    cmd_t    cmd;
    status_t st;
    tok_t    tok;

    lexsym_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    lexsym_dp #(
        .SYM_DEPTH (SYM_DEPTH),
        .NAME_MAX  (NAME_MAX),
        .POS_BITS  (POS_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_tok      (tok),
        .out_last     (last_of_run)
    );

    assign token_kind   = tok.kind;
    assign number_value = signed'(tok.value);
    assign ident_hash   = tok.hash;
    assign token_length = tok.length;
    assign start_offset = tok.start;
    assign line_number  = tok.line;
    assign symbol_index = tok.index;
    assign new_symbol   = tok.is_new;

endmodule

>>> design/lexsym_ctrl.sv
// sequencer: byte intake, symbol lookup walk and result emission
`timescale 1ns / 1ps
module lexsym_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lexsym_pkg::status_t st,
    output lexsym_pkg::cmd_t    cmd
);
    import lexsym_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (st.ident_flush)
                begin
                    if (st.too_long)
                    begin
                        cmd.lk_long = 1'b1;
                    end
                    else
                    begin
                        cmd.lk_start = 1'b1;
                        state_next   = S_LK_HREQ;
                    end
                end
                else
                begin
                    cmd.commit_eval = 1'b1;
                    state_next      = st.eval_emits ? S_EMIT : S_IDLE;
                end
            end
            S_LK_HREQ:
            begin
                if (st.i_at_count)
                begin
                    cmd.lk_miss = 1'b1;
                    state_next  = S_EVAL;
                end
                else
                begin
                    cmd.lk_rd_hash = 1'b1;
                    state_next     = S_LK_HCMP;
                end
            end
            S_LK_HCMP:
            begin
                if (st.hash_match)
                begin
                    cmd.lk_clr_j = 1'b1;
                    state_next   = S_LK_BREQ;
                end
                else
                begin
                    cmd.lk_next_i = 1'b1;
                    state_next    = S_LK_HREQ;
                end
            end
            S_LK_BREQ:
            begin
                if (st.j_at_len)
                begin
                    cmd.lk_hit = 1'b1;
                    state_next = S_EVAL;
                end
                else
                begin
                    cmd.lk_rd_name = 1'b1;
                    state_next     = S_LK_BCMP;
                end
            end
            S_LK_BCMP:
            begin
                if (st.byte_match)
                begin
                    cmd.lk_next_j = 1'b1;
                    state_next    = S_LK_BREQ;
                end
                else
                begin
                    cmd.lk_next_i = 1'b1;
                    state_next    = S_LK_HREQ;
                end
            end
            S_EMIT:
            begin
                if (st.holds_empty)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/lexsym_dp.sv
// datapath: scanner registers, symbol stores, result holding and output register
`timescale 1ns / 1ps
module lexsym_dp #(
    parameter int SYM_DEPTH = 256,
    parameter int NAME_MAX  = 32,
    parameter int POS_BITS  = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lexsym_pkg::cmd_t    cmd,
    output lexsym_pkg::status_t st,
    input  logic [7:0]          data_byte,
    input  logic                end_of_input,
    output logic                out_valid,
    input  logic                out_ready,
    output lexsym_pkg::tok_t    out_tok,
    output logic                out_last
);
    import lexsym_pkg::*;

    localparam int SW  = $clog2(SYM_DEPTH);
    localparam int CW  = $clog2(SYM_DEPTH + 1);
    localparam int NBW = $clog2(NAME_MAX);
    localparam int LW  = $clog2(NAME_MAX + 1);
    localparam int NAW = $clog2(SYM_DEPTH * NAME_MAX);
    localparam int HMW = 32 + LW;

    // scanner state
    mode_t               mode_reg, mode_next;
    logic [7:0]          pend_reg, pend_next;
    logic [31:0]         val_reg, val_next;
    logic [31:0]         hash_reg, hash_next;
    logic [23:0]         len_reg, len_next;
    logic [POS_BITS-1:0] ts_reg, ts_next;
    logic [POS_BITS-1:0] pos_reg;
    logic [23:0]         line_reg, line_next;
    logic [CW-1:0]       count_reg;

    // latched input word
    logic [7:0]          c_reg;
    logic                end_reg;
    logic [POS_BITS-1:0] p_reg;

    // lookup walk
    logic [CW-1:0]       i_reg;
    logic [LW-1:0]       j_reg;
    logic [HMW-1:0]      hrd_reg;
    logic [7:0]          nrd_reg, brd_reg;

    // stores
    logic [HMW-1:0] hmem [SYM_DEPTH];
    logic [7:0]     nmem [SYM_DEPTH * NAME_MAX];
    logic [7:0]     nbuf [NAME_MAX];

    // held results
    tok_t hold_a_reg, hold_b_reg, out_reg;
    logic hold_a_v_reg, hold_b_v_reg, out_v_reg, out_last_reg;

    tok_t            a_tok, b_tok, flush_tok, lk_tok;
    logic            a_v, b_v, flush_v, absorb;
    logic            nb_we, nm_we, cnt_ok;
    logic [NBW-1:0]  wr_col;
    logic [5:0]      dk;
    logic [31:0]     fin_hash;
    logic            out_free;
    logic [NAW-1:0]  wr_addr, rd_addr;

    function automatic logic [23:0] pos24(input logic [POS_BITS-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[23:0];
    endfunction

    function automatic tok_t mk_tok(input logic [5:0] k, input logic [31:0] v,
                                    input logic [31:0] h, input logic [23:0] l,
                                    input logic [23:0] s, input logic [23:0] ln);
        tok_t t;
        t        = '0;
        t.kind   = k;
        t.value  = v;
        t.hash   = h;
        t.length = l;
        t.start  = s;
        t.line   = ln;
        return t;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    assign fin_hash = (hash_reg << 6) + 32'(len_reg);
    assign cnt_ok   = count_reg < CW'(SYM_DEPTH);
    assign dk       = double_op(pend_reg, c_reg);
    assign out_free = !out_v_reg || out_ready;

    // token left behind by the current mode when it is cut off
    always_comb
    begin
        flush_v   = 1'b1;
        flush_tok = mk_tok(K_NUMBER, val_reg, 32'd0, 24'd0, pos24(ts_reg), line_reg);
        case (mode_reg)
            M_DEC, M_ZERO, M_OCT, M_HEX: ;
            M_STR:   flush_tok = mk_tok(K_STRING, 32'd0, 32'd0, len_reg, pos24(ts_reg),
                                        line_reg);
            M_CHR:   flush_tok.value = (len_reg != 24'd0) ? val_reg : 32'd0;
            M_SLASH: flush_tok = mk_tok(K_DIVIDE, 32'd0, 32'd0, 24'd0, pos24(ts_reg),
                                        line_reg);
            M_OP:    flush_tok = mk_tok(single_op(pend_reg), 32'd0, 32'd0, 24'd0,
                                        pos24(ts_reg), line_reg);
            default: flush_v = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        val_next  = val_reg;
        hash_next = hash_reg;
        len_next  = len_reg;
        ts_next   = ts_reg;
        line_next = line_reg;
        a_v       = 1'b0;
        a_tok     = flush_tok;
        b_v       = 1'b0;
        b_tok     = '0;
        nb_we     = 1'b0;
        nm_we     = 1'b0;
        wr_col    = len_reg[NBW-1:0];
        absorb    = 1'b0;
        if (end_reg)
        begin
            a_v       = flush_v;
            mode_next = M_IDLE;
            b_v       = 1'b1;
            b_tok     = mk_tok(K_END, 32'd0, 32'd0, 24'd0, pos24(p_reg), line_reg);
        end
        else
        begin
            case (mode_reg)
                M_CMT:
                begin
                    if (c_reg == 8'h0A || c_reg == 8'h00)
                    begin
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        absorb = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (c_reg == "/")
                    begin
                        mode_next = M_CMT;
                        absorb    = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(c_reg) || is_digit(c_reg))
                    begin
                        hash_next = hash_reg * 32'd147 + 32'(c_reg);
                        if (len_reg < 24'(NAME_MAX))
                        begin
                            nb_we = 1'b1;
                            nm_we = cnt_ok;
                        end
                        if (len_reg != SAT24)
                        begin
                            len_next = len_reg + 24'd1;
                        end
                        absorb = 1'b1;
                    end
                end
                M_DEC:
                begin
                    if (is_digit(c_reg))
                    begin
                        val_next = val_reg * 32'd10 + 32'(c_reg - 8'd48);
                        absorb   = 1'b1;
                    end
                end
                M_ZERO, M_OCT:
                begin
                    if (mode_reg == M_ZERO && (c_reg == "x" || c_reg == "X"))
                    begin
                        mode_next = M_HEX;
                        absorb    = 1'b1;
                    end
                    else if (c_reg >= "0" && c_reg <= "7")
                    begin
                        mode_next = M_OCT;
                        val_next  = (val_reg << 3) + 32'(c_reg - 8'd48);
                        absorb    = 1'b1;
                    end
                end
                M_HEX:
                begin
                    if (is_hex(c_reg))
                    begin
                        val_next = (val_reg << 4) + 32'(c_reg & 8'h0F)
                                   + ((c_reg >= "A") ? 32'd9 : 32'd0);
                        absorb   = 1'b1;
                    end
                end
                M_STR:
                begin
                    absorb = 1'b1;
                    if (c_reg == 8'h22 || c_reg == 8'h00)
                    begin
                        a_v       = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (len_reg != SAT24)
                    begin
                        len_next = len_reg + 24'd1;
                    end
                end
                M_CHR:
                begin
                    absorb = 1'b1;
                    if (len_reg == 24'd0)
                    begin
                        val_next = 32'(c_reg);
                        len_next = 24'd1;
                    end
                    if (c_reg == 8'h27 || c_reg == 8'h00)
                    begin
                        a_v         = 1'b1;
                        a_tok.value = (len_reg == 24'd0) ? 32'(c_reg) : val_reg;
                        mode_next   = M_IDLE;
                    end
                end
                M_OP:
                begin
                    if (dk != K_END)
                    begin
                        a_v       = 1'b1;
                        a_tok     = mk_tok(dk, 32'd0, 32'd0, 24'd0, pos24(ts_reg), line_reg);
                        mode_next = M_IDLE;
                        absorb    = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!absorb)
            begin
                // cut off the current token, then start one with this byte
                a_v       = flush_v;
                mode_next = M_IDLE;
                ts_next   = p_reg;
                len_next  = 24'd0;
                val_next  = 32'd0;
                if (c_reg == 8'h0A)
                begin
                    if (line_reg != SAT24)
                    begin
                        line_next = line_reg + 24'd1;
                    end
                end
                else if (c_reg == 8'h0D || c_reg == " ")
                begin
                end
                else if (c_reg == "#")
                begin
                    mode_next = M_CMT;
                end
                else if (is_alpha(c_reg))
                begin
                    mode_next = M_IDENT;
                    hash_next = 32'(c_reg);
                    len_next  = 24'd1;
                    wr_col    = '0;
                    nb_we     = 1'b1;
                    nm_we     = cnt_ok;
                end
                else if (c_reg == "0")
                begin
                    mode_next = M_ZERO;
                end
                else if (is_digit(c_reg))
                begin
                    mode_next = M_DEC;
                    val_next  = 32'(c_reg - 8'd48);
                end
                else if (c_reg == "/")
                begin
                    mode_next = M_SLASH;
                end
                else if (c_reg == 8'h22 || c_reg == 8'h27)
                begin
                    mode_next = (c_reg == 8'h22) ? M_STR : M_CHR;
                    ts_next   = p_reg + POS_BITS'(1);
                end
                else if (single_op(c_reg) != K_END)
                begin
                    mode_next = M_OP;
                    pend_next = c_reg;
                end
                else
                begin
                    b_v   = 1'b1;
                    b_tok = mk_tok(punct_kind(c_reg),
                                   (punct_kind(c_reg) == K_BAD) ? 32'(c_reg) : 32'd0,
                                   32'd0, 24'd0, pos24(p_reg), line_reg);
                end
            end
        end
    end

    // identifier result of the lookup walk
    always_comb
    begin
        lk_tok = mk_tok(K_IDENT, 32'd0, fin_hash, len_reg, pos24(ts_reg), line_reg);
        if (cmd.lk_long)
        begin
            lk_tok.kind = K_LONG;
        end
        else if (cmd.lk_hit)
        begin
            lk_tok.index = 8'(i_reg);
        end
        else if (!cnt_ok)
        begin
            lk_tok.kind = K_FULL;
        end
        else
        begin
            lk_tok.index  = 8'(count_reg);
            lk_tok.is_new = 1'b1;
        end
    end

    assign wr_addr = NAW'(count_reg[SW-1:0]) * NAW'(NAME_MAX) + NAW'(wr_col);
    assign rd_addr = NAW'(i_reg[SW-1:0]) * NAW'(NAME_MAX) + NAW'(j_reg[NBW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.commit_eval && nb_we)
        begin
            nbuf[wr_col] <= c_reg;
        end
        if (cmd.commit_eval && nm_we)
        begin
            nmem[wr_addr] <= c_reg;
        end
        if (cmd.lk_miss && cnt_ok)
        begin
            hmem[count_reg[SW-1:0]] <= {fin_hash, len_reg[LW-1:0]};
        end
        if (cmd.lk_rd_hash)
        begin
            hrd_reg <= hmem[i_reg[SW-1:0]];
        end
        if (cmd.lk_rd_name)
        begin
            nrd_reg <= nmem[rd_addr];
            brd_reg <= nbuf[j_reg[NBW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            c_reg   <= data_byte;
            end_reg <= end_of_input;
            p_reg   <= pos_reg;
        end
        if (cmd.commit_eval)
        begin
            pend_reg <= pend_next;
            val_reg  <= val_next;
            hash_reg <= hash_next;
            len_reg  <= len_next;
            ts_reg   <= ts_next;
        end
        if (cmd.commit_eval && a_v)
        begin
            hold_a_reg <= a_tok;
        end
        else if (cmd.lk_long || cmd.lk_hit || cmd.lk_miss)
        begin
            hold_a_reg <= lk_tok;
        end
        if (cmd.commit_eval && b_v)
        begin
            hold_b_reg <= b_tok;
        end
        if (cmd.emit_step && out_free)
        begin
            out_reg      <= hold_a_v_reg ? hold_a_reg : hold_b_reg;
            out_last_reg <= hold_a_v_reg ? !hold_b_v_reg : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            pos_reg      <= '0;
            line_reg     <= 24'd1;
            count_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            hold_a_v_reg <= 1'b0;
            hold_b_v_reg <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in && !end_of_input)
            begin
                pos_reg <= pos_reg + POS_BITS'(1);
            end
            if (cmd.commit_eval)
            begin
                mode_reg     <= mode_next;
                line_reg     <= line_next;
                hold_a_v_reg <= hold_a_v_reg | a_v;
                hold_b_v_reg <= b_v;
            end
            else if (cmd.lk_long || cmd.lk_hit || cmd.lk_miss)
            begin
                mode_reg     <= M_IDLE;
                hold_a_v_reg <= 1'b1;
            end
            if (cmd.lk_miss && cnt_ok)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.lk_start)
            begin
                i_reg <= '0;
            end
            else if (cmd.lk_next_i)
            begin
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.lk_clr_j)
            begin
                j_reg <= '0;
            end
            else if (cmd.lk_next_j)
            begin
                j_reg <= j_reg + LW'(1);
            end
            if (cmd.emit_step && out_free)
            begin
                out_v_reg <= 1'b1;
                if (hold_a_v_reg)
                begin
                    hold_a_v_reg <= 1'b0;
                end
                else
                begin
                    hold_b_v_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign st.ident_flush = mode_reg == M_IDENT
                            && (end_reg || !(is_alpha(c_reg) || is_digit(c_reg)));
    assign st.too_long    = len_reg > 24'(NAME_MAX);
    assign st.eval_emits  = a_v || b_v || hold_a_v_reg;
    assign st.i_at_count  = i_reg == count_reg;
    assign st.hash_match  = hrd_reg == {fin_hash, len_reg[LW-1:0]};
    assign st.j_at_len    = j_reg == len_reg[LW-1:0];
    assign st.byte_match  = nrd_reg == brd_reg;
    assign st.holds_empty = !hold_a_v_reg && !hold_b_v_reg;

    assign out_valid = out_v_reg;
    assign out_tok   = out_reg;
    assign out_last  = out_last_reg;

endmodule

>>> bench/lexsym_checker.sv
// token predictor and scoreboard for the lexer testbench
`timescale 1ns / 1ps
module lexsym_checker
    import lexsym_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_input,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [5:0]         token_kind,
    input  logic signed [31:0] number_value,
    input  logic [31:0]        ident_hash,
    input  logic [23:0]        token_length,
    input  logic [23:0]        start_offset,
    input  logic [23:0]        line_number,
    input  logic [7:0]         symbol_index,
    input  logic               new_symbol,
    input  logic               last_of_run,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    localparam int SYMS  = 256;
    localparam int NAMES = 32;

    typedef struct {
        tok_t tok;
        logic last;
    } token_exp_t;

    token_exp_t  expected_tokens[$];

    mode_t       mode;
    logic [7:0]  op_char;
    logic [31:0] acc_val;
    logic [31:0] acc_hash;
    logic [23:0] acc_len;
    logic [23:0] tok_start;
    logic [23:0] pos;
    logic [23:0] line;
    int          sym_count;
    logic [31:0] sym_hash[SYMS];
    logic [23:0] sym_len[SYMS];
    logic [7:0]  sym_name[SYMS][NAMES];
    logic [7:0]  name_buf[NAMES];

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] op_one(logic [7:0] c);
        case (c)
            "=": return K_ASSIGN;
            "+": return K_PLUS;
            "-": return K_MINUS;
            "!": return K_NOT;
            "<": return K_LT;
            ">": return K_GT;
            "&": return K_AND;
            "|": return K_OR;
            default: return K_END;
        endcase
    endfunction

    function automatic logic [5:0] op_two(logic [7:0] f, logic [7:0] c);
        if (f == "=" && c == "=") return K_EQ;
        if (f == "+" && c == "+") return K_INC;
        if (f == "-" && c == "-") return K_DEC;
        if (f == "!" && c == "=") return K_NE;
        if (f == "<" && c == "=") return K_LE;
        if (f == "<" && c == "<") return K_SHL;
        if (f == ">" && c == "=") return K_GE;
        if (f == ">" && c == ">") return K_SHR;
        if (f == "&" && c == "&") return K_LAND;
        if (f == "|" && c == "|") return K_LOR;
        return K_END;
    endfunction

    function automatic logic [5:0] punct_code(logic [7:0] c);
        case (c)
            "^": return K_XOR;
            "*": return K_STAR;
            "%": return K_PERCENT;
            "?": return K_QUEST;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            ";": return K_SEMI;
            ",": return K_COMMA;
            ":": return K_COLON;
            default: return K_BAD;
        endcase
    endfunction

    function automatic void put(logic [5:0] k, logic [31:0] v, logic [31:0] h,
                                logic [23:0] len, logic [23:0] st,
                                logic [7:0] idx, logic nw);
        token_exp_t e;
        e.tok.kind   = k;
        e.tok.value  = v;
        e.tok.hash   = h;
        e.tok.length = len;
        e.tok.start  = st;
        e.tok.line   = line;
        e.tok.index  = idx;
        e.tok.is_new = nw;
        e.last       = 1'b0;
        expected_tokens.push_back(e);
    endfunction

    function automatic void intern_name();
        logic [31:0] h;
        bit          same;
        h = (acc_hash << 6) + {8'd0, acc_len};
        if (acc_len > NAMES)
        begin
            put(K_LONG, 0, h, acc_len, tok_start, 0, 0);
            return;
        end
        for (int i = 0; i < sym_count; i++)
        begin
            same = sym_hash[i] == h && sym_len[i] == acc_len;
            for (int j = 0; j < acc_len && same; j++)
                if (sym_name[i][j] != name_buf[j]) same = 0;
            if (same)
            begin
                put(K_IDENT, 0, h, acc_len, tok_start, i[7:0], 0);
                return;
            end
        end
        if (sym_count >= SYMS)
        begin
            put(K_FULL, 0, h, acc_len, tok_start, 0, 0);
            return;
        end
        sym_hash[sym_count] = h;
        sym_len[sym_count]  = acc_len;
        for (int j = 0; j < acc_len; j++) sym_name[sym_count][j] = name_buf[j];
        put(K_IDENT, 0, h, acc_len, tok_start, sym_count[7:0], 1);
        sym_count++;
    endfunction

    function automatic void flush_token();
        case (mode)
            M_IDENT: intern_name();
            M_DEC, M_ZERO, M_OCT, M_HEX: put(K_NUMBER, acc_val, 0, 0, tok_start, 0, 0);
            M_STR:   put(K_STRING, 0, 0, acc_len, tok_start, 0, 0);
            M_CHR:   put(K_NUMBER, (acc_len != 0) ? acc_val : 0, 0, 0, tok_start, 0, 0);
            M_SLASH: put(K_DIVIDE, 0, 0, 0, tok_start, 0, 0);
            M_OP:    put(op_one(op_char), 0, 0, 0, tok_start, 0, 0);
            default: ;
        endcase
        mode = M_IDLE;
    endfunction

    function automatic void open_token(logic [7:0] c, logic [23:0] p);
        tok_start = p;
        acc_len   = 0;
        acc_val   = 0;
        if (c == 8'h0A)
        begin
            if (line != SAT24) line++;
        end
        else if (c == 8'h0D || c == " ")
        begin
        end
        else if (c == "#")
        begin
            mode = M_CMT;
        end
        else if (is_letter(c))
        begin
            mode        = M_IDENT;
            acc_hash    = {24'd0, c};
            acc_len     = 1;
            name_buf[0] = c;
        end
        else if (c == "0")
        begin
            mode = M_ZERO;
        end
        else if (is_num(c))
        begin
            mode    = M_DEC;
            acc_val = c - "0";
        end
        else if (c == "/")
        begin
            mode = M_SLASH;
        end
        else if (c == "\"" || c == "'")
        begin
            mode      = (c == "\"") ? M_STR : M_CHR;
            tok_start = p + 24'd1;
        end
        else if (op_one(c) != K_END)
        begin
            mode    = M_OP;
            op_char = c;
        end
        else if (punct_code(c) == K_BAD)
        begin
            put(K_BAD, {24'd0, c}, 0, 0, p, 0, 0);
        end
        else
        begin
            put(punct_code(c), 0, 0, 0, p, 0, 0);
        end
    endfunction

    // returns 1 when the current token swallows the byte
    function automatic bit absorb(logic [7:0] c);
        logic [5:0] k;
        case (mode)
            M_IDLE: return 0;
            M_CMT:
            begin
                if (c == 8'h0A || c == 0)
                begin
                    mode = M_IDLE;
                    return 0;
                end
                return 1;
            end
            M_SLASH:
                if (c == "/")
                begin
                    mode = M_CMT;
                    return 1;
                end
            M_IDENT:
                if (is_letter(c) || is_num(c))
                begin
                    acc_hash = acc_hash * 32'd147 + c;
                    if (acc_len < NAMES) name_buf[acc_len] = c;
                    if (acc_len != SAT24) acc_len++;
                    return 1;
                end
            M_DEC:
                if (is_num(c))
                begin
                    acc_val = acc_val * 32'd10 + (c - "0");
                    return 1;
                end
            M_ZERO, M_OCT:
            begin
                if (mode == M_ZERO && (c == "x" || c == "X"))
                begin
                    mode = M_HEX;
                    return 1;
                end
                mode = M_OCT;
                if (c >= "0" && c <= "7")
                begin
                    acc_val = acc_val * 32'd8 + (c - "0");
                    return 1;
                end
            end
            M_HEX:
                if (is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
                begin
                    acc_val = acc_val * 32'd16 + (c & 8'd15) + ((c >= "A") ? 9 : 0);
                    return 1;
                end
            M_STR:
            begin
                if (c == "\"" || c == 0) flush_token();
                else if (acc_len != SAT24) acc_len++;
                return 1;
            end
            M_CHR:
            begin
                if (acc_len == 0)
                begin
                    acc_val = {24'd0, c};
                    acc_len = 1;
                end
                if (c == "'" || c == 0) flush_token();
                return 1;
            end
            M_OP:
            begin
                k = op_two(op_char, c);
                if (k != K_END)
                begin
                    put(k, 0, 0, 0, tok_start, 0, 0);
                    mode = M_IDLE;
                    return 1;
                end
            end
            default: return 0;
        endcase
        flush_token();
        return 0;
    endfunction

    function automatic void scan_word(logic [7:0] c, logic eoi);
        int          base;
        logic [23:0] p;
        base = expected_tokens.size();
        if (eoi)
        begin
            flush_token();
            put(K_END, 0, 0, 0, pos, 0, 0);
        end
        else
        begin
            p   = pos;
            pos = pos + 24'd1;
            if (!absorb(c)) open_token(c, p);
        end
        if (expected_tokens.size() > base)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    initial
    begin
        mode      = M_IDLE;
        op_char   = 0;
        acc_val   = 0;
        acc_hash  = 0;
        acc_len   = 0;
        tok_start = 0;
        pos       = 0;
        line      = 1;
        sym_count = 0;
        errors    = 0;
        checked   = 0;
        pending   = 0;
    end

    always @(posedge clk)
    begin
        token_exp_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready) scan_word(data_byte, end_of_input);
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_tokens.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: unexpected token word kind %0d", $realtime,
                                 token_kind);
                end
                else
                begin
                    e = expected_tokens.pop_front();
                    if (token_kind !== e.tok.kind || number_value !== e.tok.value ||
                        ident_hash !== e.tok.hash || token_length !== e.tok.length ||
                        start_offset !== e.tok.start || line_number !== e.tok.line ||
                        symbol_index !== e.tok.index || new_symbol !== e.tok.is_new ||
                        last_of_run !== e.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%t: token mismatch", $realtime);
                            $display({"  exp kind %0d val %h hash %h len %0d start %0d",
                                      " line %0d idx %0d new %b last %b"},
                                     e.tok.kind, e.tok.value, e.tok.hash, e.tok.length,
                                     e.tok.start, e.tok.line, e.tok.index, e.tok.is_new,
                                     e.last);
                            $display({"  got kind %0d val %h hash %h len %0d start %0d",
                                      " line %0d idx %0d new %b last %b"},
                                     token_kind, number_value, ident_hash, token_length,
                                     start_offset, line_number, symbol_index, new_symbol,
                                     last_of_run);
                        end
                    end
                end
            end
        end
        pending = expected_tokens.size();
    end

endmodule

>>> bench/tb.sv
// testbench top: byte stimulus, receiver stalls and verdict for the lexer
`timescale 1ns / 1ps
module tb;
    import lexsym_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_WORDS = 450;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               end_of_input;
    logic               out_valid;
    logic               out_ready;
    logic [5:0]         token_kind;
    logic signed [31:0] number_value;
    logic [31:0]        ident_hash;
    logic [23:0]        token_length;
    logic [23:0]        start_offset;
    logic [23:0]        line_number;
    logic [7:0]         symbol_index;
    logic               new_symbol;
    logic               last_of_run;
    int                 errors;
    int                 pending;
    int                 checked;
    int                 words_sent;
    int                 cycles;
    bit                 calm_send;
    bit                 hold_go;

    string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string hexes   = "0123456789abcdefABCDEF";
    string ops     = "=+-!<>&|^*%?[]{}();,:/";
    string pairs   = "==!=<=<<>=>>&&||++--";
    string names[6] = '{"x", "cnt", "foo_1", "Bar", "i", "tmp9"};

    c_like_lexer_with_symbol_intern_top dut (.*);

    lexsym_checker chk (.*);

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, calm stretches, and one long hold-off on request
    always @(posedge clk)
    begin
        int  hold_left;
        int  phase_left;
        bit  calm;
        bit  held;
        if (!rst_n)
        begin
            out_ready <= 0;
        end
        else if (hold_go && !held)
        begin
            held = 1;
            hold_left = 400;
            out_ready <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 200);
                calm = ($urandom_range(0, 2) == 0);
            end
            phase_left--;
            if (calm) out_ready <= 1;
            else if ($urandom_range(0, 99) < 3)
            begin
                hold_left = $urandom_range(8, 40);
                out_ready <= 0;
            end
            else out_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    task automatic send(input logic [7:0] b, input bit eoi);
        int gap;
        int r;
        data_byte    <= b;
        end_of_input <= eoi;
        in_valid     <= 1;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (words_sent % 97 == 0) calm_send = ($urandom_range(0, 2) == 0);
        r = $urandom_range(0, 99);
        gap = calm_send ? 0 : (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                              : $urandom_range(8, 40);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send(s[i], 0);
    endtask

    task automatic send_name(input int n);
        send(letters[$urandom_range(0, letters.len() - 1)], 0);
        for (int i = 1; i < n; i++)
            if ($urandom_range(0, 3) == 0) send("0" + $urandom_range(0, 9), 0);
            else send(letters[$urandom_range(0, letters.len() - 1)], 0);
    endtask

    task automatic send_token();
        int k;
        k = $urandom_range(0, 21);
        case (k)
            0, 1, 2: send_text(names[$urandom_range(0, 5)]);
            3, 4:    send_name($urandom_range(1, 8));
            5:
            begin
                send("1" + $urandom_range(0, 8), 0);
                repeat ($urandom_range(0, 11)) send("0" + $urandom_range(0, 9), 0);
            end
            6:
            begin
                send("0", 0);
                send($urandom_range(0, 1) ? "x" : "X", 0);
                repeat ($urandom_range(0, 10)) send(hexes[$urandom_range(0, 21)], 0);
            end
            7:
            begin
                send("0", 0);
                repeat ($urandom_range(0, 5)) send("0" + $urandom_range(0, 9), 0);
            end
            8:
            begin
                send("\"", 0);
                repeat ($urandom_range(0, 6))
                    send($urandom_range(0, 9) == 0 ? 8'h0A : $urandom_range(32, 126), 0);
                if ($urandom_range(0, 7) != 0) send("\"", 0);
            end
            9:
            begin
                send("'", 0);
                repeat ($urandom_range(0, 2)) send($urandom_range(1, 255), 0);
                if ($urandom_range(0, 5) != 0) send("'", 0);
            end
            10, 11, 12: send(ops[$urandom_range(0, ops.len() - 1)], 0);
            13, 14:
            begin
                k = 2 * $urandom_range(0, 9);
                send(pairs[k], 0);
                send(pairs[k + 1], 0);
            end
            15:
            begin
                if ($urandom_range(0, 1)) send("#", 0);
                else send_text("//");
                repeat ($urandom_range(0, 6)) send($urandom_range(1, 255), 0);
                send($urandom_range(0, 3) == 0 ? 8'h00 : 8'h0A, 0);
            end
            16, 17:  send_text($urandom_range(0, 1) ? " " : "\n");
            18:      send(8'h0D, 0);
            19:      send($urandom_range(0, 255), 0);
            20:
            begin
                if ($urandom_range(0, 15) == 0) send_name($urandom_range(33, 40));
                else send($urandom_range(0, 255), 0);
            end
            default: send($urandom_range(0, 255), 1);
        endcase
        if ($urandom_range(0, 1)) send(" ", 0);
    endtask

    initial
    begin
        rst_n        = 0;
        in_valid     = 0;
        data_byte    = 0;
        end_of_input = 0;
        out_ready    = 0;
        hold_go      = 0;
        calm_send    = 0;
        words_sent   = 0;
        cycles       = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: numbers of each base, literals, comments, bad and nul bytes
        send_text("ab 0x1F 017 4294967299 'a' '' \"h\n\" == <<&&|");
        send(8'h09, 0);
        send_text("\"s");
        send(8'h00, 0);
        send_text("#c");
        send(8'h00, 0);
        send_text("//c\n/ab9\"open");
        send(8'hFF, 1);
        send_text("'");
        send(8'h00, 1);
        send_name(40);
        send(8'h00, 1);

        while (words_sent < RANDOM_WORDS)
        begin
            send_token();
            if (words_sent > 150 && !hold_go) hold_go = 1;
            if (words_sent > 300 && words_sent < 310)
            begin
                in_valid <= 0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
        end

        // fill the symbol store past its depth, then revisit an early name
        for (int i = 0; i < 270; i++)
            send_text($sformatf("%s%0d ", letters.substr(i % 53, i % 53), i / 53));
        send_text("a0 e5 x ");
        send(8'h00, 1);

        in_valid <= 0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        $display("lexer run: %0d input words, %0d tokens checked, %0d errors",
                 words_sent, checked, errors);
        $display("covered all number bases, literals, comments, operators and a full symbol store");
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> c_like_lexer_with_symbol_intern_top.f
design/lexsym_pkg.sv
design/lexsym_ctrl.sv
design/lexsym_dp.sv
design/c_like_lexer_with_symbol_intern_top.sv
bench/lexsym_checker.sv
bench/tb.sv
